@@ sv/qtpp_pkg.sv @@
`timescale 1ns / 1ps

package qtpp_pkg;

    localparam int QTPP_FIFO_DEPTH = 4;

    // Result kinds, carried on tuser.
    localparam logic [2:0] KIND_INT      = 3'd0;
    localparam logic [2:0] KIND_CID_BYTE = 3'd1;
    localparam logic [2:0] KIND_VER_WORD = 3'd2;
    localparam logic [2:0] KIND_CID_NONE = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TRUNC   = 2'd1;
    localparam logic [1:0] ERR_INVALID = 2'd2;

    // Transport parameter ids that get special handling.
    localparam logic [61:0] ID_ORIG_DCID     = 62'h00;
    localparam logic [61:0] ID_IDLE_TIMEOUT  = 62'h01;
    localparam logic [61:0] ID_INT_LOW       = 62'h03;
    localparam logic [61:0] ID_INT_HIGH      = 62'h0b;
    localparam logic [61:0] ID_ACT_CID_LIMIT = 62'h0e;
    localparam logic [61:0] ID_INIT_SCID     = 62'h0f;
    localparam logic [61:0] ID_RETRY_SCID    = 62'h10;
    localparam logic [61:0] ID_VERSION_INFO  = 62'h11;

    typedef enum logic [1:0] {
        CL_INT,
        CL_CID,
        CL_VER,
        CL_UNK
    } param_class_t;

    typedef struct packed {
        logic        run_last;
        logic [61:0] error_offset;
        logic [1:0]  error_code;
        logic        value_last;
        logic [61:0] element_index;
        logic [63:0] value_out;
        logic [61:0] param_id;
        logic [2:0]  result_kind;
    } result_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } in_beat_t;

    // Up to two results produced by one input byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } dec_wr_t;

    function automatic param_class_t classify(input logic [61:0] id);
        param_class_t cl;
        if (id == ID_ORIG_DCID || id == ID_INIT_SCID || id == ID_RETRY_SCID)
            cl = CL_CID;
        else if (id == ID_VERSION_INFO)
            cl = CL_VER;
        else if (id == ID_IDLE_TIMEOUT || (id >= ID_INT_LOW && id <= ID_INT_HIGH)
                 || id == ID_ACT_CID_LIMIT)
            cl = CL_INT;
        else
            cl = CL_UNK;
        return cl;
    endfunction

    function automatic result_t make_result(
        input logic [2:0]  kind,
        input logic [61:0] id,
        input logic [63:0] val,
        input logic [61:0] idx,
        input logic        last,
        input logic [1:0]  code,
        input logic [61:0] off
    );
        result_t r;
        r.result_kind   = kind;
        r.param_id      = id;
        r.value_out     = val;
        r.element_index = idx;
        r.value_last    = last;
        r.error_code    = code;
        r.error_offset  = off;
        r.run_last      = 1'b0;
        return r;
    endfunction

endpackage

@@ sv/qtpp_in_stage.sv @@
`timescale 1ns / 1ps

module qtpp_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qtpp_pkg::in_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output qtpp_pkg::in_beat_t out_beat
);
    import qtpp_pkg::*;

    logic     valid_reg;
    in_beat_t beat_reg;

    // The register refills in the same cycle it is drained.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

@@ sv/qtpp_decoder.sv @@
`timescale 1ns / 1ps

module qtpp_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  qtpp_pkg::in_beat_t in_beat,
    input  logic               room,
    output qtpp_pkg::dec_wr_t  wr
);
    import qtpp_pkg::*;

    typedef enum logic [2:0] {
        PH_ID_FIRST,
        PH_ID_REST,
        PH_LEN_FIRST,
        PH_LEN_REST,
        PH_VALUE,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [61:0] acc_reg, acc_next;
    logic [3:0]  vbl_reg, vbl_next;
    logic [61:0] cid_reg, cid_next;
    logic [61:0] vleft_reg, vleft_next;
    logic [61:0] off_reg, off_next;
    logic [61:0] fso_reg, fso_next;
    logic [61:0] ec_reg, ec_next;
    logic [31:0] wacc_reg, wacc_next;
    logic [1:0]  pve_reg, pve_next;
    logic        err_reg, err_next;

    logic         fire;
    logic [7:0]   b;
    logic [61:0]  off_plus1;
    logic [61:0]  new_acc;
    logic [3:0]   need;
    logic         id_done;
    logic         len_done;
    logic         vlast;
    logic [1:0]   pve_eff;
    param_class_t cl;
    logic         step_valid;
    result_t      step_res;
    logic         end_valid;
    result_t      end_res;

    assign in_ready  = room;
    assign fire      = in_valid && room;
    assign b         = in_beat.data_byte;
    assign off_plus1 = off_reg + 62'd1;
    assign need      = 4'd1 << b[7:6];

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        vbl_next   = vbl_reg;
        cid_next   = cid_reg;
        vleft_next = vleft_reg;
        off_next   = off_reg;
        fso_next   = fso_reg;
        ec_next    = ec_reg;
        wacc_next  = wacc_reg;
        pve_next   = pve_reg;
        err_next   = err_reg;
        new_acc    = acc_reg;
        id_done    = 1'b0;
        len_done   = 1'b0;
        vlast      = 1'b0;
        pve_eff    = pve_reg;
        cl         = classify(cid_reg);
        step_valid = 1'b0;
        step_res   = '0;
        end_valid  = 1'b0;
        end_res    = '0;

        case (phase_reg)
            PH_ID_FIRST, PH_LEN_FIRST:
            begin
                new_acc  = {56'd0, b[5:0]};
                acc_next = new_acc;
                vbl_next = need - 4'd1;
                fso_next = off_reg;
                if (vbl_next != 4'd0)
                    phase_next = (phase_reg == PH_ID_FIRST) ? PH_ID_REST : PH_LEN_REST;
                else if (phase_reg == PH_ID_FIRST)
                    id_done = 1'b1;
                else
                    len_done = 1'b1;
            end
            PH_ID_REST, PH_LEN_REST:
            begin
                new_acc  = {acc_reg[53:0], b};
                acc_next = new_acc;
                vbl_next = vbl_reg - 4'd1;
                if (vbl_next == 4'd0)
                begin
                    if (phase_reg == PH_ID_REST)
                        id_done = 1'b1;
                    else
                        len_done = 1'b1;
                end
            end
            PH_VALUE:
            begin
                vleft_next = vleft_reg - 62'd1;
                vlast      = (vleft_next == 62'd0);
                case (cl)
                    CL_CID:
                    begin
                        step_valid = 1'b1;
                        step_res   = make_result(KIND_CID_BYTE, cid_reg, {56'd0, b}, ec_reg,
                                                 vlast, ERR_NONE, 62'd0);
                    end
                    CL_INT:
                    begin
                        if (ec_reg == 62'd0)
                        begin
                            acc_next = {56'd0, b[5:0]};
                            if (vleft_reg < {58'd0, need})
                                pve_eff = ERR_TRUNC;
                            else if (vleft_reg > {58'd0, need})
                                pve_eff = ERR_INVALID;
                            pve_next = pve_eff;
                        end
                        else if (pve_reg == ERR_NONE)
                        begin
                            acc_next = {acc_reg[53:0], b};
                        end
                        if (vlast)
                        begin
                            step_valid = 1'b1;
                            if (pve_eff != ERR_NONE)
                            begin
                                step_res   = make_result(KIND_ERROR, 62'd0, 64'd0, 62'd0,
                                                         1'b0, pve_eff, off_plus1);
                                err_next   = 1'b1;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                step_res = make_result(KIND_INT, cid_reg, {2'b00, acc_next},
                                                       62'd0, 1'b1, ERR_NONE, 62'd0);
                            end
                        end
                    end
                    CL_VER:
                    begin
                        wacc_next = {wacc_reg[23:0], b};
                        if (pve_reg == ERR_NONE && ec_reg[1:0] == 2'd3)
                        begin
                            step_valid = 1'b1;
                            step_res   = make_result(KIND_VER_WORD, cid_reg,
                                                     {32'd0, wacc_next},
                                                     {2'b00, ec_reg[61:2]}, vlast,
                                                     ERR_NONE, 62'd0);
                        end
                        if (vlast && pve_reg != ERR_NONE)
                        begin
                            step_valid = 1'b1;
                            step_res   = make_result(KIND_ERROR, 62'd0, 64'd0, 62'd0, 1'b0,
                                                     pve_reg, off_plus1);
                            err_next   = 1'b1;
                            phase_next = PH_SKIP;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                ec_next = ec_reg + 62'd1;
                if (vlast && phase_next == PH_VALUE)
                    phase_next = PH_ID_FIRST;
            end
            default:
            begin
            end
        endcase

        if (id_done)
        begin
            cid_next   = new_acc;
            fso_next   = off_plus1;
            phase_next = PH_LEN_FIRST;
        end

        // The length varint is complete: set up the value, or settle an empty one.
        if (len_done)
        begin
            fso_next   = off_plus1;
            phase_next = PH_ID_FIRST;
            if (new_acc == 62'd0)
            begin
                case (cl)
                    CL_INT, CL_VER:
                    begin
                        step_valid = 1'b1;
                        step_res   = make_result(KIND_ERROR, 62'd0, 64'd0, 62'd0, 1'b0,
                                                 (cl == CL_INT) ? ERR_TRUNC : ERR_INVALID,
                                                 off_plus1);
                        err_next   = 1'b1;
                        phase_next = PH_SKIP;
                    end
                    CL_CID:
                    begin
                        step_valid = 1'b1;
                        step_res   = make_result(KIND_CID_NONE, cid_reg, 64'd0, 62'd0, 1'b1,
                                                 ERR_NONE, 62'd0);
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                vleft_next = new_acc;
                ec_next    = 62'd0;
                wacc_next  = 32'd0;
                acc_next   = 62'd0;
                pve_next   = (cl == CL_VER && new_acc[1:0] != 2'd0) ? ERR_INVALID : ERR_NONE;
                phase_next = PH_VALUE;
            end
        end

        if (in_beat.end_of_block)
        begin
            if (!err_next)
            begin
                end_valid = 1'b1;
                if (phase_next == PH_ID_FIRST)
                    end_res = make_result(KIND_DONE, 62'd0, 64'd0, 62'd0, 1'b0,
                                          ERR_NONE, 62'd0);
                else
                    end_res = make_result(KIND_ERROR, 62'd0, 64'd0, 62'd0, 1'b0,
                                          ERR_TRUNC, fso_next);
            end
            phase_next = PH_ID_FIRST;
            acc_next   = 62'd0;
            vbl_next   = 4'd0;
            cid_next   = 62'd0;
            vleft_next = 62'd0;
            off_next   = 62'd0;
            fso_next   = 62'd0;
            ec_next    = 62'd0;
            wacc_next  = 32'd0;
            pve_next   = ERR_NONE;
            err_next   = 1'b0;
        end
        else
        begin
            off_next = off_plus1;
        end

        // Pack the results of this byte into the write slots.
        wr = '0;
        if (fire)
        begin
            if (step_valid)
            begin
                wr.r0 = step_res;
                wr.r1 = end_res;
            end
            else
            begin
                wr.r0 = end_res;
            end
            wr.count = {1'b0, step_valid} + {1'b0, end_valid};
            if (wr.count == 2'd2)
                wr.r1.run_last = 1'b1;
            else if (wr.count == 2'd1)
                wr.r0.run_last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID_FIRST;
            acc_reg   <= '0;
            vbl_reg   <= '0;
            cid_reg   <= '0;
            vleft_reg <= '0;
            off_reg   <= '0;
            fso_reg   <= '0;
            ec_reg    <= '0;
            wacc_reg  <= '0;
            pve_reg   <= ERR_NONE;
            err_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            vbl_reg   <= vbl_next;
            cid_reg   <= cid_next;
            vleft_reg <= vleft_next;
            off_reg   <= off_next;
            fso_reg   <= fso_next;
            ec_reg    <= ec_next;
            wacc_reg  <= wacc_next;
            pve_reg   <= pve_next;
            err_reg   <= err_next;
        end
    end

endmodule

@@ sv/qtpp_out_fifo.sv @@
`timescale 1ns / 1ps

module qtpp_out_fifo #(
    parameter int FIFO_DEPTH = qtpp_pkg::QTPP_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  qtpp_pkg::dec_wr_t wr,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output qtpp_pkg::result_t out_res
);
    import qtpp_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t          mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd;

    // Room for the two results a single byte can produce.
    assign room      = count_reg <= CNT_W'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem[rd_ptr_reg];
    assign rd        = out_valid && out_ready;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(wr.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(rd);
    assign count_next  = count_reg + CNT_W'(wr.count) - CNT_W'(rd);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr.r0;
        end
        if (wr.count == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= wr.r1;
        end
    end

endmodule

@@ sv/quic_transport_param_parser_top.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// s_axis    in   tdata: data_byte; tlast: end_of_block
// m_axis    out  tdata: id, value, index and error fields; tuser: result_kind; tlast: run_last
//
// A byte accepted on s_axis is held in the input register; the decoder then updates its
// state from that register and writes zero, one or two result beats into the output
// queue, from which m_axis takes them. A new byte is taken every cycle while the queue
// holds at most FIFO_DEPTH - 2 beats; s_axis stalls only when result beats pile up faster
// than m_axis drains them, and nothing is lost.
// Reset clears the decoder state and empties the queue at once, with no clearing pass.

module quic_transport_param_parser_top #(
    parameter int FIFO_DEPTH = qtpp_pkg::QTPP_FIFO_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [61:0] param_id, [125:62] value_out, [187:126] element_index,
    // [188] value_last, [190:189] error_code, [252:191] error_offset, rest zero
    output logic [255:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // [2:0] result_kind
    output logic         m_axis_tlast
);
    import qtpp_pkg::*;

    in_beat_t s_beat;
    in_beat_t dec_beat;
    logic     dec_valid;
    logic     dec_ready;
    logic     room;
    dec_wr_t  wr;
    result_t  out_res;

    assign s_beat.data_byte    = s_axis_tdata;
    assign s_beat.end_of_block = s_axis_tlast;

    qtpp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_beat   (s_beat),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_beat  (dec_beat)
    );

    qtpp_decoder u_decoder (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dec_valid),
        .in_ready (dec_ready),
        .in_beat  (dec_beat),
        .room     (room),
        .wr       (wr)
    );

    qtpp_out_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // Payload fields packed from the lowest bit up, padded to whole bytes.
    assign m_axis_tdata = {3'b000,
                           out_res.error_offset,
                           out_res.error_code,
                           out_res.value_last,
                           out_res.element_index,
                           out_res.value_out,
                           out_res.param_id};
    assign m_axis_tuser = out_res.result_kind;
    assign m_axis_tlast = out_res.run_last;

endmodule
